// ===== rtl/kway_merge_dedup_heap_assert.svh =====
// assertion macros for the k-way merge block
// used by kway_merge_dedup_heap.sv, no other dependencies
`ifndef KWAY_MERGE_DEDUP_HEAP_ASSERT_SVH
`define KWAY_MERGE_DEDUP_HEAP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KMDH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kmdh check failed");
`define KMDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmdh check failed");
`else
`define KMDH_ASSERT(lbl, clk, rst_n, prop)
`define KMDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kmdh_pkg.sv =====
// shared types and constants for the k-way merge block
// no dependencies; imported by kmdh_cell and kway_merge_dedup_heap
package kmdh_pkg;

    localparam int KEY_PORT_BITS  = 64;
    localparam int LANE_PORT_BITS = 4;
    localparam int MASK_PORT_BITS = 16;
    localparam int MAX_LANES      = 16;
    localparam int CNT_BITS       = 5;
    localparam logic [CNT_BITS-1:0] LANES_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_EXHAUST = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    // command from the sequencer to one lane cell
    typedef struct packed {
        logic load;
        logic mark_exh;
        logic restart;
    } t_cell_cmd;

    // control part of the token that walks along the cell row
    typedef struct packed {
        logic valid;
        logic live;
    } t_sweep_ctl;

endpackage

// ===== rtl/kmdh_cell.sv =====
// one lane cell: head key, exhausted flag and one stage of the minimum sweep
// depends on kmdh_pkg
module kmdh_cell
    import kmdh_pkg::*;
#(
    parameter int KEY_BITS  = 64,
    parameter int LANE_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_cmd            i_cmd,
    input  logic [KEY_BITS-1:0]  i_key,
    input  logic                 i_in_use,
    input  t_sweep_ctl           i_ctl,
    input  logic [KEY_BITS-1:0]  i_min_key,
    input  logic [MAX_LANES-1:0] i_mask,
    output t_sweep_ctl           o_ctl,
    output logic [KEY_BITS-1:0]  o_min_key,
    output logic [MAX_LANES-1:0] o_mask
);

    localparam logic [MAX_LANES-1:0] SELF_BIT = {{(MAX_LANES-1){1'b0}}, 1'b1} << LANE_IDX;

    logic [KEY_BITS-1:0]  r_key;
    logic                 r_exh;
    logic                 r_valid;
    logic                 r_live;
    logic [KEY_BITS-1:0]  r_min_key;
    logic [MAX_LANES-1:0] r_mask;

    logic                 me_live;
    logic                 n_live;
    logic [KEY_BITS-1:0]  n_min_key;
    logic [MAX_LANES-1:0] n_mask;

    assign me_live = i_in_use && !r_exh;

    always_comb begin
        n_live    = i_ctl.live | me_live;
        n_min_key = i_min_key;
        n_mask    = i_mask;
        if (me_live) begin
            if (!i_ctl.live || (r_key < i_min_key)) begin
                n_min_key = r_key;
                n_mask    = SELF_BIT;
            end else if (r_key == i_min_key) begin
                n_mask = i_mask | SELF_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_exh   <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
            if (i_cmd.restart || i_cmd.load) begin
                r_exh <= 1'b0;
            end else if (i_cmd.mark_exh) begin
                r_exh <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
        // token payload only moves with a valid token, so the row end stays stable
        if (i_ctl.valid) begin
            r_live    <= n_live;
            r_min_key <= n_min_key;
            r_mask    <= n_mask;
        end
    end

    assign o_ctl     = '{valid: r_valid, live: r_live};
    assign o_min_key = r_min_key;
    assign o_mask    = r_mask;

endmodule

// ===== rtl/kway_merge_dedup_heap.sv =====
// top level of the k-way merge with duplicate removal: sequencer, pending set,
// output register and the row of lane cells; depends on kmdh_pkg, kmdh_cell
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_opcode, i_lane, i_key
//  result    out        o_out_valid / i_out_stall   o_min_key, o_refill_mask, o_all_done
//  config    in         i_cfg_we                    i_cfg_data (lanes_in_use)
//
// a transaction that leaves lanes pending does not stall the input.
// the transaction that fills the last pending lane starts a sweep through the
// cell row, one cell a cycle; the result then passes the hold state into the
// output register, with the input stalled meanwhile.
// reset is synchronous: lanes_in_use = 16, all lanes in use pending.
// new transactions are taken while a result waits in the output register; a
// finished sweep holds at the row end until that register is free.
`include "kway_merge_dedup_heap_assert.svh"
module kway_merge_dedup_heap
    import kmdh_pkg::*;
#(
    parameter int KEY_BITS  = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CNT_BITS-1:0]       i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic [LANE_PORT_BITS-1:0] i_lane,
    input  logic [KEY_PORT_BITS-1:0]  i_key,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [KEY_PORT_BITS-1:0]  o_min_key,
    output logic [MASK_PORT_BITS-1:0] o_refill_mask,
    output logic                      o_all_done
);

    localparam int OUT_LANES = (MAX_LANES < MASK_PORT_BITS) ? MAX_LANES : MASK_PORT_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_HOLD  = 3'b100
    } t_state;

    t_state                    r_state;
    logic                      r_launch;
    logic [CNT_BITS-1:0]       r_lanes_in_use;
    logic [MAX_LANES-1:0]      r_in_use;
    logic [MAX_LANES-1:0]      r_pending;
    logic                      r_out_valid;
    logic [KEY_PORT_BITS-1:0]  r_out_key;
    logic [MASK_PORT_BITS-1:0] r_out_mask;
    logic                      r_out_done;

    t_sweep_ctl           w_ctl  [MAX_LANES+1];
    logic [KEY_BITS-1:0]  w_key  [MAX_LANES+1];
    logic [MAX_LANES-1:0] w_mask [MAX_LANES+1];
    logic [MAX_LANES:0]   w_valid;
    t_cell_cmd            w_cmd  [MAX_LANES];

    t_opcode                   op;
    logic                      is_idle;
    logic                      in_acc;
    logic [MAX_LANES-1:0]      lane_sel;
    logic                      refill;
    logic                      do_restart;
    logic [CNT_BITS-1:0]       restart_cnt;
    logic [MAX_LANES-1:0]      pending_after;
    logic                      launch;
    logic                      row_done;
    logic                      out_free;
    logic [MASK_PORT_BITS-1:0] end_mask;
    logic                      out_zero;

    function automatic logic [MAX_LANES-1:0] f_in_use(input logic [CNT_BITS-1:0] cnt);
        int                   act;
        logic [MAX_LANES-1:0] v;
        act = int'(cnt);
        if (act < 1) act = 1;
        if (act > MAX_LANES) act = MAX_LANES;
        for (int g = 0; g < MAX_LANES; g++) begin
            v[g] = (g < act);
        end
        return v;
    endfunction

    assign op         = t_opcode'(i_opcode);
    assign is_idle    = (r_state == S_IDLE);
    assign o_in_stall = !is_idle;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        for (int g = 0; g < MAX_LANES; g++) begin
            lane_sel[g] = (32'(i_lane) == g);
        end
    end

    assign refill        = in_acc && ((op == OP_KEY) || (op == OP_EXHAUST))
                           && ((lane_sel & r_pending) != '0);
    assign do_restart    = i_cfg_we || (in_acc && (op == OP_RESTART));
    assign restart_cnt   = i_cfg_we ? i_cfg_data : r_lanes_in_use;
    assign pending_after = r_pending & ~lane_sel;
    assign launch        = refill && (pending_after == '0);
    assign row_done      = w_ctl[MAX_LANES].valid;
    assign out_free      = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int g = 0; g < MAX_LANES; g++) begin
            w_cmd[g].load     = refill && (op == OP_KEY) && lane_sel[g];
            w_cmd[g].mark_exh = refill && (op == OP_EXHAUST) && lane_sel[g];
            w_cmd[g].restart  = do_restart;
        end
    end

    // token enters with no live lane seen yet
    assign w_ctl[0]  = '{valid: r_launch, live: 1'b0};
    assign w_key[0]  = '0;
    assign w_mask[0] = '0;

    for (genvar g = 0; g < MAX_LANES; g++) begin : g_cell
        kmdh_cell #(
            .KEY_BITS  (KEY_BITS),
            .LANE_IDX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd[g]),
            .i_key     (i_key[KEY_BITS-1:0]),
            .i_in_use  (r_in_use[g]),
            .i_ctl     (w_ctl[g]),
            .i_min_key (w_key[g]),
            .i_mask    (w_mask[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_min_key (w_key[g+1]),
            .o_mask    (w_mask[g+1])
        );
    end

    always_comb begin
        for (int g = 0; g <= MAX_LANES; g++) begin
            w_valid[g] = w_ctl[g].valid;
        end
    end

    always_comb begin
        end_mask = '0;
        end_mask[OUT_LANES-1:0] = w_mask[MAX_LANES][OUT_LANES-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_launch       <= 1'b0;
            r_lanes_in_use <= LANES_RESET;
            r_in_use       <= f_in_use(LANES_RESET);
            r_pending      <= f_in_use(LANES_RESET);
            r_out_valid    <= 1'b0;
        end else begin
            r_launch <= launch;
            if (i_cfg_we) begin
                r_lanes_in_use <= i_cfg_data;
            end
            if (do_restart) begin
                r_in_use  <= f_in_use(restart_cnt);
                r_pending <= f_in_use(restart_cnt);
            end else if (refill) begin
                r_pending <= pending_after;
            end else if (row_done) begin
                // lanes holding the minimum must refill; none once all are exhausted
                r_pending <= w_ctl[MAX_LANES].live ? w_mask[MAX_LANES] : '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (launch) r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (row_done) r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if ((r_state == S_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_HOLD) && out_free) begin
            if (w_ctl[MAX_LANES].live) begin
                r_out_key  <= KEY_PORT_BITS'(w_key[MAX_LANES]);
                r_out_mask <= end_mask;
                r_out_done <= 1'b0;
            end else begin
                r_out_key  <= '0;
                r_out_mask <= '0;
                r_out_done <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_key     = r_out_key;
    assign o_refill_mask = r_out_mask;
    assign o_all_done    = r_out_done;

    assign out_zero = (o_min_key == '0) && (o_refill_mask == '0);

    `KMDH_ASSERT(a_one_token, i_clk, i_rst_n, $onehot0(w_valid))
    `KMDH_ASSERT(a_idle_row_empty, i_clk, i_rst_n, is_idle |-> (w_valid == '0))
    `KMDH_ASSERT(a_pending_in_use, i_clk, i_rst_n, (r_pending & ~r_in_use) == '0)
    `KMDH_ASSERT(a_sweep_no_pending, i_clk, i_rst_n, (r_state == S_SWEEP) |-> (r_pending == '0))
    `KMDH_ASSERT(a_done_clean, i_clk, i_rst_n, (o_out_valid && o_all_done) |-> out_zero)
    `KMDH_ASSERT_NEXT(a_launch_sweeps, i_clk, i_rst_n, launch, (r_state == S_SWEEP) && r_launch)

endmodule
